[sv/text_preview_sanitizer_assert.svh]
// assertion helpers for the text preview sanitizer
// the user module must have clk and arst_n in scope
`ifndef TEXT_PREVIEW_SANITIZER_ASSERT_SVH
`define TEXT_PREVIEW_SANITIZER_ASSERT_SVH

// same-cycle implication
`define TPS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/tps_pkg.sv]
`default_nettype none

package tps_pkg;

	localparam int LIMIT_WIDTH_DEF = 12;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int PKT_BYTES       = 4;

	// one input request
	typedef struct packed {
		logic [7:0] text_byte;
		logic       final_byte;
	} tps_in_t;

	// one result request
	typedef struct packed {
		logic [7:0] out_byte;
		logic       string_end;
	} tps_out_t;

	// work handed from front to back: up to four bytes, then maybe an end item
	typedef struct packed {
		logic [PKT_BYTES-1:0][7:0] data;
		logic [2:0]                cnt;
		logic                      closes;
	} tps_pkt_t;

endpackage

`default_nettype wire

[sv/tps_front.sv]
`default_nettype none

module tps_front #(
	parameter int LIMIT_WIDTH = 12
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	input  wire logic [LIMIT_WIDTH-1:0] cfg_data,
	input  wire logic                   item_valid,
	output logic                        item_ready,
	input  wire tps_pkg::tps_in_t       item,
	input  wire logic                   q_full,
	output logic                        pkt_push,
	output tps_pkg::tps_pkt_t           pkt
);
	import tps_pkg::*;

	localparam int LIMIT_MAX = (1 << LIMIT_WIDTH) - 1;
	localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET =
		LIMIT_WIDTH'((LIMIT_MAX < 127) ? LIMIT_MAX : 127);
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_QMARK = 8'h3F;

	typedef struct packed {
		logic [2:0][7:0] data;
		logic [1:0]      cnt;
	} clean_t;

	function automatic logic [1:0] lead_need(input logic [7:0] b);
		logic [1:0] n;
		n = 2'd0;
		priority if ((b & 8'hE0) == 8'hC0) n = 2'd1;
		else if ((b & 8'hF0) == 8'hE0) n = 2'd2;
		else if ((b & 8'hF8) == 8'hF0) n = 2'd3;
		else n = 2'd0;
		return n;
	endfunction

	function automatic logic [7:0] plain_byte(input logic [7:0] b);
		logic [7:0] r;
		r = CHAR_QMARK;
		priority if (b >= 8'h20 && b <= 8'h7E) r = b;
		else if (b >= 8'h09 && b <= 8'h0D) r = CHAR_SPACE;
		else r = CHAR_QMARK;
		return r;
	endfunction

	// held bytes of a cut sequence: lead gives '?', a complete pair behind it passes raw
	function automatic clean_t clean_held(input logic [2:0][7:0] h, input logic [1:0] n);
		clean_t c;
		c.data = '0;
		c.cnt  = n;
		c.data[0] = CHAR_QMARK;
		c.data[1] = plain_byte(h[1]);
		c.data[2] = plain_byte(h[2]);
		if (n == 2'd3 && lead_need(h[1]) == 2'd1) begin
			c.data[1] = h[1];
			c.data[2] = h[2];
		end
		return c;
	endfunction

	logic [LIMIT_WIDTH-1:0] limit_q;
	logic [LIMIT_WIDTH-1:0] seen_q;
	logic [LIMIT_WIDTH-1:0] seen_n;
	logic [2:0][7:0]        held_q;
	logic [2:0][7:0]        held_src;
	logic [1:0]             hc_q;
	logic [1:0]             need_q;
	logic                   leading_q;
	logic                   closed_q;

	logic       accept;
	logic [7:0] b;
	logic [7:0] pb;
	logic [1:0] ln;
	logic       close_now;
	logic       close_after;
	logic       complete;
	logic       hold;
	logic [1:0] n_src;
	clean_t     cl;

	assign b           = item.text_byte;
	assign pb          = plain_byte(b);
	assign ln          = lead_need(b);
	assign seen_n      = seen_q + LIMIT_WIDTH'(1);
	assign close_now   = (b == 8'd0) || (seen_q >= limit_q);
	assign close_after = item.final_byte || (seen_n >= limit_q);
	assign complete    = (hc_q != 2'd0) && (hc_q >= need_q);
	assign hold        = (hc_q != 2'd0) ? !complete : (ln != 2'd0);
	assign item_ready  = !q_full;
	assign accept      = item_valid && item_ready;

	always_comb begin
		held_src = held_q;
		n_src    = hc_q;
		if (!close_now && hold) begin
			held_src[hc_q] = b;
			n_src          = hc_q + 2'd1;
		end
	end

	assign cl = clean_held(held_src, n_src);

	always_comb begin
		pkt = '0;
		if (!closed_q) begin
			if (close_now) begin
				pkt.data[2:0] = cl.data;
				pkt.cnt       = {1'b0, cl.cnt};
				pkt.closes    = 1'b1;
			end else if (complete) begin
				pkt.data[2:0]  = held_q;
				pkt.data[hc_q] = b;
				pkt.cnt        = {1'b0, hc_q} + 3'd1;
				pkt.closes     = close_after;
			end else if (hold) begin
				if (close_after) begin
					pkt.data[2:0] = cl.data;
					pkt.cnt       = {1'b0, cl.cnt};
					pkt.closes    = 1'b1;
				end
			end else begin
				// leading spaces are dropped
				if (!(leading_q && pb == CHAR_SPACE)) begin
					pkt.data[0] = pb;
					pkt.cnt     = 3'd1;
				end
				pkt.closes = close_after;
			end
		end
	end

	assign pkt_push = accept && (pkt.cnt != 3'd0 || pkt.closes);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !closed_q && !close_now && hold) begin
			held_q[hc_q] <= b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= '0;
			hc_q      <= '0;
			need_q    <= '0;
			leading_q <= 1'b1;
			closed_q  <= 1'b0;
		end else if (accept) begin
			if (item.final_byte) begin
				// the final byte always starts a fresh text
				seen_q    <= '0;
				hc_q      <= '0;
				need_q    <= '0;
				leading_q <= 1'b1;
				closed_q  <= 1'b0;
			end else if (!closed_q) begin
				leading_q <= leading_q && (pkt.cnt == 3'd0);
				if (close_now) begin
					hc_q     <= '0;
					need_q   <= '0;
					closed_q <= 1'b1;
				end else begin
					seen_q <= seen_n;
					if (close_after || complete) begin
						hc_q     <= '0;
						need_q   <= '0;
						closed_q <= close_after;
					end else if (hold) begin
						hc_q <= hc_q + 2'd1;
						if (hc_q == 2'd0) begin
							need_q <= ln;
						end
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

[sv/tps_queue.sv]
`default_nettype none

module tps_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire tps_pkg::tps_pkt_t push_pkt,
	output logic                   full,
	output logic                   head_valid,
	output tps_pkg::tps_pkt_t      head_pkt,
	input  wire logic              pop
);
	import tps_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	tps_pkt_t        slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full       = (count_q == FULL_CNT);
	assign head_valid = (count_q != '0);
	assign head_pkt   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_pkt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[sv/tps_back.sv]
`default_nettype none

module tps_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              head_valid,
	input  wire tps_pkg::tps_pkt_t head_pkt,
	output logic                   pop,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output tps_pkg::tps_out_t      result
);
	import tps_pkg::*;

	logic [2:0] idx_q;
	logic       load;
	logic       at_end;
	logic       last;
	tps_out_t   cur;

	// past the bytes comes the end item, if the packet closes the string
	assign at_end = (idx_q == head_pkt.cnt);
	assign last   = head_pkt.closes ? at_end : (idx_q == head_pkt.cnt - 3'd1);
	assign load   = !result_valid || result_ready;
	assign pop    = load && head_valid && last;

	always_comb begin
		cur.out_byte   = at_end ? 8'd0 : head_pkt.data[idx_q[1:0]];
		cur.string_end = at_end;
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			result <= cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
			idx_q        <= '0;
		end else if (load) begin
			result_valid <= head_valid;
			if (head_valid) begin
				idx_q <= last ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

endmodule

`default_nettype wire

[sv/text_preview_sanitizer.sv]
// a result passes the packet queue and then the output register after its request is accepted
// throughput: one request per cycle while the queue has room; one result per cycle while the receiver is ready
// a request causing k results holds the output side until all k are taken; the queue absorbs bursts
// reset: arst_n asynchronous active low; limit returns to 127, string state clears
// no clearing pass after reset; requests are taken on the first cycle out of reset
`default_nettype none
`include "text_preview_sanitizer_assert.svh"

module text_preview_sanitizer #(
	parameter int LIMIT_WIDTH = tps_pkg::LIMIT_WIDTH_DEF,
	parameter int QUEUE_DEPTH = tps_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// configuration write: the preview limit
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [LIMIT_WIDTH-1:0] cfg_data,
	// raw text requests
	input  wire logic                   item_valid,
	output logic                        item_ready,
	input  wire tps_pkg::tps_in_t       item,
	// cleaned preview requests
	output logic                        result_valid,
	input  wire logic                   result_ready,
	output tps_pkg::tps_out_t           result
);
	import tps_pkg::*;

	// front to queue
	logic     pkt_push;
	tps_pkt_t pkt;
	logic     q_full;
	// queue to back
	logic     q_valid;
	tps_pkt_t q_pkt;
	logic     q_pop;

	// the user must write the limit only while idle; the block does not enforce it and the register takes writes at once
	assign cfg_ready = 1'b1;

	// front: classifies each byte, tracks utf-8 sequences, limit and leading spaces
	// and turns each request into at most one packet of up to four bytes plus an end mark
	tps_front #(
		.LIMIT_WIDTH(LIMIT_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item      (item),
		.q_full    (q_full),
		.pkt_push  (pkt_push),
		.pkt       (pkt)
	);

	// short packet queue so front and back stall on their own
	tps_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (pkt_push),
		.push_pkt  (pkt),
		.full      (q_full),
		.head_valid(q_valid),
		.head_pkt  (q_pkt),
		.pop       (q_pop)
	);

	// back: walks the head packet one result per cycle, while the receiver is ready, into the output register
	tps_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (q_valid),
		.head_pkt    (q_pkt),
		.pop         (q_pop),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	// front never writes a full queue
	`TPS_ASSERT_NOW(a_no_push_full, pkt_push, !q_full, "packet pushed into full queue")
	// back only pops what is there
	`TPS_ASSERT_NOW(a_pop_has_data, q_pop, q_valid, "pop from empty queue")
	// a push without a pop leaves the queue holding work
	`TPS_ASSERT_NEXT(a_push_fills, pkt_push && !q_pop, q_valid, "pushed packet lost")
	// the end item carries a zero byte
	`TPS_ASSERT_NOW(a_end_zero, result_valid && result.string_end, result.out_byte == 8'd0,
		"end item with nonzero byte")

endmodule

`default_nettype wire

[tb/tb_text_preview_sanitizer.sv]
`default_nettype none

module tb_text_preview_sanitizer;
	import tps_pkg::*;

	localparam int LW = LIMIT_WIDTH_DEF;

	// character codes the cleaner produces
	localparam logic [7:0] NUL   = 8'h00;
	localparam logic [7:0] SPACE = 8'h20;
	localparam logic [7:0] MARK  = 8'h3F;   // '?'

	localparam int MAX_BURST   = 5;      // most results one request can cause
	localparam int HOLD_AFTER  = 120;    // results taken before the long receiver hold-off
	localparam int HOLD_CYCLES = 80;
	localparam int QUIET_LIMIT = 1000;   // cycles with no handshake at all before giving up
	localparam int SETTLE      = 5;      // extra wait after the last expected result is out

	logic          clk;
	logic          arst_n       = 1'b0;
	logic          cfg_valid    = 1'b0;
	logic          cfg_ready;
	logic [LW-1:0] cfg_data     = '0;
	logic          item_valid   = 1'b0;
	logic          item_ready;
	tps_in_t       item         = '0;
	logic          result_valid;
	logic          result_ready = 1'b0;
	tps_out_t      result;

	text_preview_sanitizer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// cleaner state as the testbench sees it
	// ------------------------------------------------------------------
	logic [LW-1:0] limit_now   = LW'(127);   // preview limit out of reset
	logic [7:0]    held [3];                 // utf-8 lead byte plus followers so far
	int unsigned   held_n      = 0;
	int unsigned   follow_need = 0;
	bit            stripping   = 1'b1;       // still dropping leading blanks
	logic [LW-1:0] taken       = '0;         // bytes counted into the current string
	bit            closed      = 1'b0;       // end request already sent, waiting for final
	int unsigned   burst_n;                  // results caused by the current request

	tps_out_t      preview_due [$];          // expected results, oldest first
	tps_in_t       pending [$];              // requests not yet offered
	int            items_left    = 0;        // requests queued but not yet accepted
	int unsigned   requests_made = 0;
	int            bad_results   = 0;
	int            results_taken = 0;
	int            quiet_cycles  = 0;
	bit            calm          = 1'b0;     // no random idling on either side

	// number of continuation bytes a utf-8 lead byte asks for
	function automatic int unsigned follower_count(input logic [7:0] b);
		if (b[7:5] == 3'b110) return 1;
		if (b[7:4] == 4'b1110) return 2;
		if (b[7:3] == 5'b11110) return 3;
		return 0;
	endfunction

	// printable ascii passes, other whitespace turns into a blank, the rest is marked
	function automatic logic [7:0] clean_byte(input logic [7:0] b);
		if (b >= 8'h20 && b <= 8'h7E) return b;
		if (b >= 8'h09 && b <= 8'h0D) return SPACE;
		return MARK;
	endfunction

	task automatic queue_preview(input logic [7:0] b, input logic last);
		tps_out_t r;
		if (burst_n >= MAX_BURST) return;
		r.out_byte   = b;
		r.string_end = last;
		preview_due.push_back(r);
		burst_n++;
	endtask

	// blanks before the first real character are swallowed
	task automatic send_char(input logic [7:0] c);
		if (stripping && c == SPACE) return;
		stripping = 1'b0;
		queue_preview(c, 1'b0);
	endtask

	task automatic restart_string();
		held_n      = 0;
		follow_need = 0;
		stripping   = 1'b1;
		taken       = '0;
		closed      = 1'b0;
	endtask

	// a cut sequence is cleaned again as a string that ends here, then the end request
	task automatic close_preview();
		int unsigned i, n_f, k;
		i = 0;
		while (i < held_n) begin
			n_f = follower_count(held[i]);
			if (n_f > 0 && i + n_f + 1 <= held_n) begin
				for (k = 0; k <= n_f; k++)
					send_char(held[i + k]);
				i += n_f + 1;
			end else begin
				send_char(clean_byte(held[i]));
				i++;
			end
		end
		held_n      = 0;
		follow_need = 0;
		queue_preview(NUL, 1'b1);
		closed = 1'b1;
	endtask

	// works out the results of one accepted text request
	task automatic sanitize_request(input tps_in_t r);
		logic [7:0]  b;
		int unsigned n_f, k;
		b       = r.text_byte;
		burst_n = 0;
		if (!closed) begin
			if (b == NUL || taken >= limit_now) begin
				close_preview();
			end else begin
				taken = taken + LW'(1);
				if (held_n > 0) begin
					if (held_n >= follow_need || held_n >= 3) begin
						for (k = 0; k < held_n && k < 3; k++)
							send_char(held[k]);
						send_char(b);
						held_n      = 0;
						follow_need = 0;
					end else begin
						held[held_n] = b;
						held_n++;
					end
				end else begin
					n_f = follower_count(b);
					if (n_f > 0) begin
						held[0]     = b;
						held_n      = 1;
						follow_need = n_f;
					end else begin
						send_char(clean_byte(b));
					end
				end
				if (r.final_byte || taken >= limit_now)
					close_preview();
			end
		end
		// the final byte always starts a fresh text
		if (r.final_byte)
			restart_string();
	endtask

	// ------------------------------------------------------------------
	// stimulus building
	// ------------------------------------------------------------------
	task automatic add_byte(input logic [7:0] b, input logic fin);
		tps_in_t r;
		r.text_byte  = b;
		r.final_byte = fin;
		pending.push_back(r);
		items_left++;
		requests_made++;
	endtask

	// lead byte with keep of its n_f followers; fin marks the last byte pushed
	task automatic add_utf8(input int unsigned n_f, input int unsigned keep, input logic fin);
		logic [7:0]  lead;
		int unsigned k;
		case (n_f)
		1: begin
			lead = {3'b110, 5'($urandom)};
		end
		2: begin
			lead = {4'b1110, 4'($urandom)};
		end
		default: begin
			lead = {5'b11110, 3'($urandom)};
		end
		endcase
		add_byte(lead, fin && keep == 0);
		for (k = 1; k <= keep; k++)
			add_byte({2'b10, 6'($urandom)}, fin && k == keep);
	endtask

	// mostly well-formed texts with random content, each closed by a final byte
	task automatic add_text(input int unsigned count);
		int unsigned goal, len, k, pick, ends, n_f;
		goal = requests_made + count;
		while (requests_made < goal) begin
			// leading blanks now and then
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(3, 1))
					add_byte(($urandom_range(1) != 0) ? SPACE : 8'($urandom_range(13, 9)), 1'b0);
			len = ($urandom_range(7) == 0) ? $urandom_range(50, 20) : $urandom_range(12, 1);
			for (k = 0; k < len; k++) begin
				pick = $urandom_range(99);
				if (pick < 45)
					add_byte(8'($urandom_range(8'h7E, 8'h20)), 1'b0);
				else if (pick < 55)
					add_byte(8'($urandom_range(13, 9)), 1'b0);
				else if (pick < 88)
					add_utf8($urandom_range(3, 1), 3, 1'b0);
				else
					add_byte(8'($urandom_range(255)), 1'b0);
			end
			ends = $urandom_range(9);
			if (ends < 6) begin
				add_byte(8'($urandom_range(255)), 1'b1);
			end else if (ends < 8) begin
				// zero byte closes early, the rest is skipped up to the final byte
				add_byte(NUL, 1'b0);
				repeat ($urandom_range(2))
					add_byte(8'($urandom_range(255)), 1'b0);
				add_byte(8'($urandom_range(255)), 1'b1);
			end else begin
				// sequence cut short by the final byte
				n_f = $urandom_range(3, 1);
				add_utf8(n_f, $urandom_range(n_f - 1, 0), 1'b1);
			end
		end
	endtask

	// wait until every request is in and every expected result is out
	task automatic drain();
		do @(negedge clk);
		while (items_left != 0 || preview_due.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LW-1:0] v);
		@(posedge clk);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		limit_now = v;
	endtask

	task automatic report_bad(input string what, input tps_out_t want, input tps_out_t got);
		bad_results++;
		if (bad_results <= 10)
			$display("%0t %s: expected byte %02h end %0d, got byte %02h end %0d", $time, what,
				want.out_byte, want.string_end, got.out_byte, got.string_end);
	endtask

	// ------------------------------------------------------------------
	// sender: offers queued text requests, idles now and then
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				sanitize_request(item);
				items_left--;
			end
			// an offered request stays put until it is taken
			if (item_valid && !item_ready) begin
				item_valid <= 1'b1;
			end else if (pending.size() != 0 && (calm || $urandom_range(99) >= 6)) begin
				item       <= pending.pop_front();
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// receiver: random stalls plus one long hold-off to back up the block
	// ------------------------------------------------------------------
	int hold_left = 0;
	bit held_off  = 1'b0;

	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left    <= hold_left - 1;
			result_ready <= 1'b0;
		end else if (!held_off && results_taken >= HOLD_AFTER) begin
			hold_left    <= HOLD_CYCLES;
			held_off     <= 1'b1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= calm || $urandom_range(99) >= 6;
		end
	end

	// compare each result request with the oldest expectation
	always @(posedge clk) begin : check_results
		tps_out_t want;
		if (arst_n && result_valid && result_ready) begin
			results_taken <= results_taken + 1;
			if (preview_due.size() == 0) begin
				report_bad("result with nothing pending", '0, result);
			end else begin
				want = preview_due.pop_front();
				if (result.out_byte !== want.out_byte || result.string_end !== want.string_end)
					report_bad("wrong result", want, result);
			end
		end
	end

	// ------------------------------------------------------------------
	// watchdog: too long without any handshake means the block is stuck
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("text_preview_sanitizer: mismatch");
		$finish;
	end

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// default limit: blank stripping, each byte class, full utf-8 sequences,
		// zero byte closing early, skipped bytes, a cut sequence holding a whole pair
		add_byte(SPACE, 1'b0); add_byte(8'h09, 1'b0); add_byte(8'h41, 1'b0);
		add_byte(8'h7E, 1'b0); add_byte(8'h0D, 1'b0); add_byte(8'h7F, 1'b0);
		add_byte(8'h80, 1'b0); add_byte(8'hFF, 1'b0); add_byte(8'h01, 1'b0);
		add_byte(8'hC3, 1'b0); add_byte(8'hA9, 1'b0);
		add_byte(8'hE2, 1'b0); add_byte(8'h82, 1'b0); add_byte(8'hAC, 1'b0);
		add_byte(8'hF0, 1'b0); add_byte(8'h9F, 1'b0); add_byte(8'h98, 1'b0);
		add_byte(8'h80, 1'b0);
		add_byte(NUL, 1'b0); add_byte(8'h78, 1'b0); add_byte(8'h79, 1'b1);
		add_byte(8'hF0, 1'b0); add_byte(8'hC3, 1'b0); add_byte(8'hA9, 1'b1);
		drain();

		// limit of one: every string holds at most one byte
		write_limit(LW'(1));
		add_text(15);
		drain();

		// largest limit: strings end only at zero or final bytes
		write_limit({LW{1'b1}});
		add_text(75);
		drain();

		// short limits cut most strings, no idling in this stretch
		write_limit(LW'($urandom_range(8, 2)));
		@(negedge clk) calm = 1'b1;
		add_text(50);
		drain();
		@(negedge clk) calm = 1'b0;

		write_limit(LW'($urandom_range(40, 9)));
		add_text(50);
		drain();

		if (bad_results == 0 && preview_due.size() == 0)
			$display("text_preview_sanitizer: match");
		else
			$display("text_preview_sanitizer: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
